// ===== rtl/core/vrrp_pkg.sv =====
// Shared types and constants for the VRRPv2 router role machine.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package vrrp_pkg;

  // Timer width: the longest load is 3 * 255 s + 1 s in microseconds (< 2^30).
  localparam int unsigned DurW       = 30;
  localparam int unsigned UsecPerSec = 1_000_000;
  localparam int unsigned DownMult   = 3;
  localparam int unsigned PrioSpan   = 256;
  localparam int unsigned SkewShift  = $clog2(PrioSpan);
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [7:0] PrioOwner   = 8'd255;
  localparam logic [7:0] PrioQuit    = 8'd0;
  localparam logic [7:0] TtlRequired = 8'd255;
  localparam logic [3:0] VerRequired = 4'd2;
  localparam logic [7:0] AuthNone    = 8'd0;

  typedef enum logic [1:0] {
    RoleInit    = 2'd0,
    RoleBackup  = 2'd1,
    RoleMaster  = 2'd2,
    RoleStopped = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    OpTick     = 2'd0,
    OpAdvert   = 2'd1,
    OpShutdown = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MacNone    = 2'd0,
    MacVirtual = 2'd1,
    MacReal    = 2'd2
  } mac_e;

  typedef enum logic [3:0] {
    VerdictNone     = 4'd0,
    VerdictAccept   = 4'd1,
    VerdictTtl      = 4'd2,
    VerdictVersion  = 4'd3,
    VerdictLength   = 4'd4,
    VerdictChecksum = 4'd5,
    VerdictVrid     = 4'd6,
    VerdictAuth     = 4'd7,
    VerdictAddress  = 4'd8,
    VerdictInterval = 4'd9
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRouterId      = 3'd0,
    CfgLocalPriority = 3'd1,
    CfgPreempt       = 3'd2,
    CfgAdverInterval = 3'd3,
    CfgLocalIp       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]      router_id;
    logic [7:0]      local_priority;
    logic            preempt_enable;
    logic [7:0]      adver_interval_sec;
    logic [31:0]     local_ip;
    logic [DurW-1:0] adver_us;
    logic [DurW-1:0] skew_us;
    logic [DurW-1:0] down_us;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ttl;
    logic [3:0]  version;
    logic        length_ok;
    logic        checksum_ok;
    logic [7:0]  vrid;
    logic [7:0]  auth_kind;
    logic        addrs_match;
    logic [7:0]  interval;
    logic [7:0]  prio;
    logic [31:0] source_ip;
  } item_t;

  typedef struct packed {
    role_e      role;
    logic       send_advert;
    logic [7:0] advert_priority;
    mac_e       mac_action;
    logic       send_garp;
    verdict_e   verdict;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/vrrp_cfg_regs.sv =====
// Configuration registers and the timer durations derived from them.
// Depends on vrrp_pkg.
`default_nettype none

module vrrp_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [vrrp_pkg::CfgIdxW-1:0]  wr_index_i,
  input  wire logic [31:0]                   wr_data_i,
  output vrrp_pkg::cfg_t                     cfg_o
);

  logic [7:0]  router_id_q;
  logic [7:0]  local_priority_q;
  logic        preempt_enable_q;
  logic [7:0]  adver_interval_q;
  logic [31:0] local_ip_q;

  logic [vrrp_pkg::DurW-1:0] adver_us_q, adver_us_d;
  logic [vrrp_pkg::DurW-1:0] skew_us_q, skew_us_d;
  logic [vrrp_pkg::DurW-1:0] down_us_q, down_us_d;
  logic [8:0]                prio_gap;
  logic [vrrp_pkg::DurW-1:0] skew_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      router_id_q      <= 8'd1;
      local_priority_q <= 8'd100;
      preempt_enable_q <= 1'b1;
      adver_interval_q <= 8'd1;
      local_ip_q       <= 32'd0;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        vrrp_pkg::CfgRouterId:      router_id_q      <= wr_data_i[7:0];
        vrrp_pkg::CfgLocalPriority: local_priority_q <= wr_data_i[7:0];
        vrrp_pkg::CfgPreempt:       preempt_enable_q <= wr_data_i[0];
        vrrp_pkg::CfgAdverInterval: adver_interval_q <= wr_data_i[7:0];
        vrrp_pkg::CfgLocalIp:       local_ip_q       <= wr_data_i;
        default: ;
      endcase
    end
  end

  // Durations in microseconds; skew = (256 - prio) * 1e6 / 256.
  always_comb begin
    prio_gap   = 9'(vrrp_pkg::PrioSpan) - {1'b0, local_priority_q};
    adver_us_d = vrrp_pkg::DurW'(adver_interval_q) * vrrp_pkg::DurW'(vrrp_pkg::UsecPerSec);
    skew_prod  = vrrp_pkg::DurW'(prio_gap) * vrrp_pkg::DurW'(vrrp_pkg::UsecPerSec);
    skew_us_d  = skew_prod >> vrrp_pkg::SkewShift;
    down_us_d  = vrrp_pkg::DurW'(adver_interval_q)
               * vrrp_pkg::DurW'(vrrp_pkg::DownMult * vrrp_pkg::UsecPerSec)
               + skew_us_d;
  end

  // Refresh every cycle; the durations are registered from the config fields above.
  always_ff @(posedge clk_i) begin
    adver_us_q <= adver_us_d;
    skew_us_q  <= skew_us_d;
    down_us_q  <= down_us_d;
  end

  assign cfg_o.router_id          = router_id_q;
  assign cfg_o.local_priority     = local_priority_q;
  assign cfg_o.preempt_enable     = preempt_enable_q;
  assign cfg_o.adver_interval_sec = adver_interval_q;
  assign cfg_o.local_ip           = local_ip_q;
  assign cfg_o.adver_us           = adver_us_q;
  assign cfg_o.skew_us            = skew_us_q;
  assign cfg_o.down_us            = down_us_q;

endmodule

`default_nettype wire

// ===== rtl/core/vrrp_hdr_chk.sv =====
// Advertisement header checks, first failing check gives the drop code.
// Depends on vrrp_pkg.
`default_nettype none

module vrrp_hdr_chk (
  input  wire vrrp_pkg::item_t item_i,
  input  wire vrrp_pkg::cfg_t  cfg_i,
  output vrrp_pkg::verdict_e   verdict_o
);

  always_comb begin
    priority if (item_i.ttl != vrrp_pkg::TtlRequired)     verdict_o = vrrp_pkg::VerdictTtl;
    else if (item_i.version != vrrp_pkg::VerRequired)     verdict_o = vrrp_pkg::VerdictVersion;
    else if (!item_i.length_ok)                           verdict_o = vrrp_pkg::VerdictLength;
    else if (!item_i.checksum_ok)                         verdict_o = vrrp_pkg::VerdictChecksum;
    else if (item_i.vrid != cfg_i.router_id)              verdict_o = vrrp_pkg::VerdictVrid;
    else if (item_i.auth_kind != vrrp_pkg::AuthNone)      verdict_o = vrrp_pkg::VerdictAuth;
    else if (!item_i.addrs_match)                         verdict_o = vrrp_pkg::VerdictAddress;
    else if (item_i.interval != cfg_i.adver_interval_sec) verdict_o = vrrp_pkg::VerdictInterval;
    else                                                  verdict_o = vrrp_pkg::VerdictAccept;
  end

endmodule

`default_nettype wire

// ===== rtl/core/vrrp_role_fsm.sv =====
// Role state machine with the advertisement and master-down timers.
// Depends on vrrp_pkg; takes the header verdict from vrrp_hdr_chk.
`default_nettype none

module vrrp_role_fsm (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire vrrp_pkg::item_t    item_i,
  input  wire vrrp_pkg::verdict_e hdr_verdict_i,
  input  wire vrrp_pkg::cfg_t     cfg_i,
  output vrrp_pkg::result_t       result_o
);

  vrrp_pkg::role_e           role_q, role_d;
  logic [vrrp_pkg::DurW-1:0] adver_cnt_q, adver_cnt_d;
  logic [vrrp_pkg::DurW-1:0] down_cnt_q, down_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q      <= vrrp_pkg::RoleInit;
      adver_cnt_q <= '0;
      down_cnt_q  <= '0;
    end else if (step_i) begin
      role_q      <= role_d;
      adver_cnt_q <= adver_cnt_d;
      down_cnt_q  <= down_cnt_d;
    end
  end

  always_comb begin
    logic accepted;
    logic outranked;
    role_d      = role_q;
    adver_cnt_d = adver_cnt_q;
    down_cnt_d  = down_cnt_q;
    result_o    = '0;
    accepted    = (hdr_verdict_i == vrrp_pkg::VerdictAccept);
    outranked   = (item_i.prio > cfg_i.local_priority)
               || (item_i.prio == cfg_i.local_priority && item_i.source_ip > cfg_i.local_ip);

    unique case (role_q)
      vrrp_pkg::RoleInit: begin
        if (cfg_i.local_priority == vrrp_pkg::PrioOwner) begin
          result_o.send_advert     = 1'b1;
          result_o.advert_priority = cfg_i.local_priority;
          result_o.mac_action      = vrrp_pkg::MacVirtual;
          result_o.send_garp       = 1'b1;
          adver_cnt_d              = cfg_i.adver_us;
          down_cnt_d               = '0;
          role_d                   = vrrp_pkg::RoleMaster;
        end else begin
          adver_cnt_d = '0;
          down_cnt_d  = cfg_i.down_us;
          role_d      = vrrp_pkg::RoleBackup;
        end
      end
      vrrp_pkg::RoleMaster: begin
        if (item_i.op == vrrp_pkg::OpShutdown) begin
          result_o.send_advert     = 1'b1;
          result_o.advert_priority = vrrp_pkg::PrioQuit;
          result_o.mac_action      = vrrp_pkg::MacReal;
          adver_cnt_d              = '0;
          down_cnt_d               = '0;
          role_d                   = vrrp_pkg::RoleStopped;
        end else if (item_i.op == vrrp_pkg::OpTick) begin
          if (adver_cnt_q <= vrrp_pkg::DurW'(1)) begin
            result_o.send_advert     = 1'b1;
            result_o.advert_priority = cfg_i.local_priority;
            adver_cnt_d              = cfg_i.adver_us;
          end else begin
            adver_cnt_d = adver_cnt_q - vrrp_pkg::DurW'(1);
          end
        end else if (item_i.op == vrrp_pkg::OpAdvert) begin
          result_o.verdict = hdr_verdict_i;
          if (accepted) begin
            if (item_i.prio == vrrp_pkg::PrioQuit) begin
              result_o.send_advert     = 1'b1;
              result_o.advert_priority = cfg_i.local_priority;
              adver_cnt_d              = cfg_i.adver_us;
            end else if (outranked) begin
              result_o.mac_action = vrrp_pkg::MacReal;
              adver_cnt_d         = '0;
              down_cnt_d          = cfg_i.down_us;
              role_d              = vrrp_pkg::RoleBackup;
            end
          end
        end
      end
      vrrp_pkg::RoleBackup: begin
        if (item_i.op == vrrp_pkg::OpShutdown) begin
          adver_cnt_d = '0;
          down_cnt_d  = '0;
          role_d      = vrrp_pkg::RoleStopped;
        end else if (item_i.op == vrrp_pkg::OpTick) begin
          if (down_cnt_q <= vrrp_pkg::DurW'(1)) begin
            result_o.send_advert     = 1'b1;
            result_o.advert_priority = cfg_i.local_priority;
            result_o.mac_action      = vrrp_pkg::MacVirtual;
            result_o.send_garp       = 1'b1;
            adver_cnt_d              = cfg_i.adver_us;
            down_cnt_d               = '0;
            role_d                   = vrrp_pkg::RoleMaster;
          end else begin
            down_cnt_d = down_cnt_q - vrrp_pkg::DurW'(1);
          end
        end else if (item_i.op == vrrp_pkg::OpAdvert) begin
          result_o.verdict = hdr_verdict_i;
          if (accepted) begin
            if (item_i.prio == vrrp_pkg::PrioQuit) begin
              down_cnt_d = cfg_i.skew_us;
            end else if (!cfg_i.preempt_enable || item_i.prio >= cfg_i.local_priority) begin
              down_cnt_d = cfg_i.down_us;
            end
          end
        end
      end
      vrrp_pkg::RoleStopped: ;
      default: ;
    endcase

    result_o.role = role_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/vrrp_v2_router_state_machine.sv =====
// Top level of the VRRPv2 router role machine: input stage, result stage,
// and the config, header check and role machine submodules. Depends on vrrp_pkg.
`default_nettype none

// Usage
//   Input channel (in_valid_i/in_ready_o): one transfer per item, op 0 is a
//   one-microsecond tick, op 1 a pre-parsed advertisement, op 2 a shutdown.
//   Output channel (out_valid_o/out_ready_i): exactly one result per item, in
//   order: role after the step, advertisement/MAC/ARP requests, header verdict.
//   Config channel (cfg_valid_i/cfg_ready_o): always ready; cfg_index_i picks
//   the register (0 router id .. 4 local IP), unknown indexes are ignored.
//   Write config only while no item is in flight.
// Stages and throughput
//   An accepted item lands in the input register; the role machine evaluates it
//   combinationally and its result is registered in the result stage when the
//   item steps, which raises out_valid_o. One item per cycle sustained while
//   out_ready_i is high; the role and timer registers feed back through
//   combinational logic only.
// Reset
//   rst_ni clears both stages, puts the role in init with both timers at zero
//   and loads the default configuration. The first item, whatever its op, leaves init.
// Stall
//   While out_ready_i is low the result holds; an empty input stage still takes
//   one more item, after which in_ready_o stays low until the result moves.
module vrrp_v2_router_state_machine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  adv_ttl_i,
  input  wire logic [3:0]  adv_version_i,
  input  wire logic        adv_length_ok_i,
  input  wire logic        adv_checksum_ok_i,
  input  wire logic [7:0]  adv_vrid_i,
  input  wire logic [7:0]  adv_auth_kind_i,
  input  wire logic        adv_addrs_match_i,
  input  wire logic [7:0]  adv_interval_i,
  input  wire logic [7:0]  adv_priority_i,
  input  wire logic [31:0] adv_source_ip_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       role_o,
  output logic             send_advert_o,
  output logic [7:0]       advert_priority_o,
  output logic [1:0]       mac_action_o,
  output logic             send_garp_o,
  output logic [3:0]       verdict_o,

  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [vrrp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i
);

  vrrp_pkg::cfg_t     cfg;
  vrrp_pkg::item_t    item_q, item_d;
  vrrp_pkg::result_t  res_q, res_d;
  vrrp_pkg::verdict_e hdr_verdict;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               out_adv;   // result stage free to load this cycle
  logic               step;      // input-stage item moves to the result stage

  assign cfg_ready_o = 1'b1;

  vrrp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Flow control: the result stage loads when empty or when its transfer
  // completes; the input stage refills in the same cycle it drains.
  assign out_adv    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_adv;
  assign in_ready_o = !in_valid_q || out_adv;

  always_comb begin
    item_d.op          = op_i;
    item_d.ttl         = adv_ttl_i;
    item_d.version     = adv_version_i;
    item_d.length_ok   = adv_length_ok_i;
    item_d.checksum_ok = adv_checksum_ok_i;
    item_d.vrid        = adv_vrid_i;
    item_d.auth_kind   = adv_auth_kind_i;
    item_d.addrs_match = adv_addrs_match_i;
    item_d.interval    = adv_interval_i;
    item_d.prio        = adv_priority_i;
    item_d.source_ip   = adv_source_ip_i;
  end

  // Input stage: valid is control, payload loads on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  vrrp_hdr_chk u_hdr_chk (
    .item_i    (item_q),
    .cfg_i     (cfg),
    .verdict_o (hdr_verdict)
  );

  // Role and timers advance only when the item leaves the input stage.
  vrrp_role_fsm u_role_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (item_q),
    .hdr_verdict_i (hdr_verdict),
    .cfg_i         (cfg),
    .result_o      (res_d)
  );

  // Result stage: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign role_o            = res_q.role;
  assign send_advert_o     = res_q.send_advert;
  assign advert_priority_o = res_q.advert_priority;
  assign mac_action_o      = res_q.mac_action;
  assign send_garp_o       = res_q.send_garp;
  assign verdict_o         = res_q.verdict;

  // Gratuitous ARP only goes out on taking over as master with the virtual MAC.
  a_garp_on_takeover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_garp_o |->
      mac_action_o == vrrp_pkg::MacVirtual && role_o == vrrp_pkg::RoleMaster)
    else $error("gratuitous ARP without master takeover");

  // No priority is reported without an advertisement request.
  a_prio_needs_advert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_advert_o |-> advert_priority_o == 8'd0)
    else $error("advert priority set without advertisement");

  // Stopped is terminal: any later result is stopped too.
  a_stopped_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && role_o == vrrp_pkg::RoleStopped |=>
      !out_valid_o || role_o == vrrp_pkg::RoleStopped)
    else $error("role left stopped");

  // A blocked result stage does not advance the role machine.
  a_no_step_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !step)
    else $error("role machine stepped while result stage blocked");

endmodule

`default_nettype wire
